>>> rtl/fpa_pkg.sv
// shared types and constants for the q24.8 fixed-point alu
// no dependencies
`default_nettype none

package fpa_pkg;

	localparam int WORD_BITS = 32;

	typedef enum logic [3:0] {
		OP_ADD  = 4'd0,
		OP_SUB  = 4'd1,
		OP_MUL  = 4'd2,
		OP_DIV  = 4'd3,
		OP_LT   = 4'd4,
		OP_GT   = 4'd5,
		OP_LE   = 4'd6,
		OP_GE   = 4'd7,
		OP_EQ   = 4'd8,
		OP_NE   = 4'd9,
		OP_MIN  = 4'd10,
		OP_MAX  = 4'd11,
		OP_INC  = 4'd12,
		OP_DEC  = 4'd13,
		OP_FROM = 4'd14,
		OP_TOI  = 4'd15
	} op_t;

	typedef struct packed {
		logic [3:0]                  opcode;
		logic signed [WORD_BITS-1:0] operand_a;
		logic signed [WORD_BITS-1:0] operand_b;
	} req_t;

	typedef struct packed {
		logic signed [WORD_BITS-1:0] result_value;
		logic                        compare_true;
		logic                        overflow;
		logic                        divide_by_zero;
	} rsp_t;

	// per-item context that rides along the divider chain
	typedef struct packed {
		logic                 is_mul;
		logic                 is_div;
		logic                 neg;
		logic [WORD_BITS-1:0] mb;
		logic [WORD_BITS-1:0] res;
		logic                 cmp;
		logic                 ov;
		logic                 dz;
	} ctx_t;

	localparam logic [WORD_BITS-1:0] SAT_POS = {1'b0, {(WORD_BITS-1){1'b1}}};
	localparam logic [WORD_BITS-1:0] SAT_NEG = {1'b1, {(WORD_BITS-1){1'b0}}};

endpackage

`default_nettype wire

>>> rtl/fpa_cell.sv
// one restoring-division cell: takes one numerator bit, yields one quotient bit
// depends on fpa_pkg
`default_nettype none

module fpa_cell #(
	parameter int FRAC_BITS = 8
) (
	input  wire                                          clk,
	input  wire                                          arst_n,
	input  wire                                          en,
	input  wire                                          in_valid,
	input  fpa_pkg::ctx_t                                in_ctx,
	input  wire [fpa_pkg::WORD_BITS-1:0]                 in_rem,
	input  wire [fpa_pkg::WORD_BITS+FRAC_BITS-1:0]       in_nq,
	output logic                                         out_valid,
	output fpa_pkg::ctx_t                                out_ctx,
	output logic [fpa_pkg::WORD_BITS-1:0]                out_rem,
	output logic [fpa_pkg::WORD_BITS+FRAC_BITS-1:0]      out_nq
);
	import fpa_pkg::*;

	localparam int NB = WORD_BITS + FRAC_BITS;

	logic [WORD_BITS:0]   trial;
	logic                 ge;
	logic [WORD_BITS:0]   diff;
	logic [WORD_BITS-1:0] rem_d;

	always_comb begin
		trial = {in_rem, in_nq[NB-1]};
		ge    = trial >= {1'b0, in_ctx.mb};
		diff  = trial - {1'b0, in_ctx.mb};
		rem_d = ge ? diff[WORD_BITS-1:0] : trial[WORD_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_ctx <= in_ctx;
			out_rem <= rem_d;
			out_nq  <= {in_nq[NB-2:0], ge};
		end
	end

endmodule

`default_nettype wire

>>> rtl/fixed_point_q24_8_alu_unit.sv
// q24.8 signed fixed-point alu: decode stage, multiply stage, chain of division cells
// depends on fpa_pkg and fpa_cell
// pipeline registers in order: stage 1, stage 2, one register per division cell, output register
// throughput: one item per cycle while req_stall is low; every opcode walks the same pipeline, so order is kept
// an output register with a skid stage decouples rsp_stall from req_stall
// reset clears all valid bits and the skid; payload registers are not reset
`default_nettype none

module fixed_point_q24_8_alu_unit #(
	parameter int FRAC_BITS = 8
) (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           req_valid,
	output logic          req_stall,
	input  fpa_pkg::req_t req,
	output logic          rsp_valid,
	input  wire           rsp_stall,
	output fpa_pkg::rsp_t rsp
);
	import fpa_pkg::*;

	localparam int W  = WORD_BITS;
	localparam int NB = W + FRAC_BITS;
	localparam int FW = 2 * W + 1;
	localparam logic [FW-1:0] HALF = FW'(1) << (FRAC_BITS - 1);
	localparam logic [FW-1:0] LIM_POS = FW'(SAT_POS);
	localparam logic [FW-1:0] LIM_NEG = FW'(SAT_NEG);

	// magnitude back to a word, saturating
	function automatic logic [W:0] finish(input logic neg, input logic [FW-1:0] m);
		logic n;
		logic [W:0] r;
		n = neg && (m != '0);
		if (m > (n ? LIM_NEG : LIM_POS))
			r = {1'b1, n ? SAT_NEG : SAT_POS};
		else
			r = {1'b0, n ? (~m[W-1:0] + W'(1)) : m[W-1:0]};
		return r;
	endfunction

	logic en;
	assign en = !req_stall;

	// decode and simple operations
	logic [W-1:0] a, b, bb, ma, mb;
	logic [W:0]   sum, dif;
	logic         lt, gt, eq, from_ok;
	ctx_t         ctx_d;

	always_comb begin
		a  = req.operand_a;
		b  = req.operand_b;
		bb = (req.opcode == OP_INC || req.opcode == OP_DEC) ? W'(1) : b;
		sum = {a[W-1], a} + {bb[W-1], bb};
		dif = {a[W-1], a} - {bb[W-1], bb};
		lt = $signed(a) < $signed(b);
		gt = $signed(a) > $signed(b);
		eq = a == b;
		ma = a[W-1] ? (~a + W'(1)) : a;
		mb = b[W-1] ? (~b + W'(1)) : b;
		from_ok = (a[W-1 -: FRAC_BITS+1] == '0) || (a[W-1 -: FRAC_BITS+1] == '1);
		ctx_d = '0;
		ctx_d.mb  = mb;
		ctx_d.neg = a[W-1] ^ b[W-1];
		unique case (req.opcode) inside
			OP_ADD, OP_INC: begin
				ctx_d.ov  = sum[W] != sum[W-1];
				ctx_d.res = ctx_d.ov ? (sum[W] ? SAT_NEG : SAT_POS) : sum[W-1:0];
			end
			OP_SUB, OP_DEC: begin
				ctx_d.ov  = dif[W] != dif[W-1];
				ctx_d.res = ctx_d.ov ? (dif[W] ? SAT_NEG : SAT_POS) : dif[W-1:0];
			end
			OP_MUL: ctx_d.is_mul = 1'b1;
			OP_DIV: begin
				if (b == '0) begin
					ctx_d.dz  = 1'b1;
					ctx_d.res = a[W-1] ? SAT_NEG : SAT_POS;
				end else begin
					ctx_d.is_div = 1'b1;
				end
			end
			OP_LT:  ctx_d.cmp = lt;
			OP_GT:  ctx_d.cmp = gt;
			OP_LE:  ctx_d.cmp = !gt;
			OP_GE:  ctx_d.cmp = !lt;
			OP_EQ:  ctx_d.cmp = eq;
			OP_NE:  ctx_d.cmp = !eq;
			OP_MIN: ctx_d.res = lt ? a : b;
			OP_MAX: ctx_d.res = gt ? a : b;
			OP_FROM: begin
				ctx_d.ov  = !from_ok;
				ctx_d.res = from_ok ? (a << FRAC_BITS) : (a[W-1] ? SAT_NEG : SAT_POS);
			end
			default: ctx_d.res = W'($signed(a) >>> FRAC_BITS);
		endcase
	end

	// stage 1: decoded context
	logic         v_s1, v_s2;
	ctx_t         ctx_s1, ctx_s2;
	logic [W-1:0] ma_s1, ma_s2;
	logic [2*W-1:0] p_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= req_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s1 <= ctx_d;
			ma_s1  <= ma;
			ctx_s2 <= ctx_s1;
			ma_s2  <= ma_s1;
			p_s2   <= (2*W)'(ma_s1) * (2*W)'(ctx_s1.mb);
		end
	end

	// multiply rounding and division setup
	logic [FW-1:0] prod_r;
	logic [W:0]    mul_fin;
	ctx_t          ctx_c0;

	always_comb begin
		prod_r  = ({1'b0, p_s2} + HALF) >> FRAC_BITS;
		mul_fin = finish(ctx_s2.neg, prod_r);
		ctx_c0  = ctx_s2;
		if (ctx_s2.is_mul) begin
			ctx_c0.res = mul_fin[W-1:0];
			ctx_c0.ov  = mul_fin[W];
		end
	end

	// division cell chain
	logic          cv   [0:NB];
	ctx_t          cctx [0:NB];
	logic [W-1:0]  crem [0:NB];
	logic [NB-1:0] cnq  [0:NB];

	assign cv[0]   = v_s2;
	assign cctx[0] = ctx_c0;
	assign crem[0] = '0;
	assign cnq[0]  = {ma_s2, {FRAC_BITS{1'b0}}};

	genvar gi;
	generate
		for (gi = 0; gi < NB; gi++) begin : g_cell
			fpa_cell #(.FRAC_BITS(FRAC_BITS)) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.en        (en),
				.in_valid  (cv[gi]),
				.in_ctx    (cctx[gi]),
				.in_rem    (crem[gi]),
				.in_nq     (cnq[gi]),
				.out_valid (cv[gi+1]),
				.out_ctx   (cctx[gi+1]),
				.out_rem   (crem[gi+1]),
				.out_nq    (cnq[gi+1])
			);
		end
	endgenerate

	// division rounding and result assembly
	ctx_t          lctx;
	logic          rnd;
	logic [FW-1:0] qr;
	logic [W:0]    div_fin;
	rsp_t          last;

	always_comb begin
		lctx    = cctx[NB];
		rnd     = crem[NB] >= (lctx.mb - crem[NB]);
		qr      = FW'(cnq[NB]) + FW'(rnd);
		div_fin = finish(lctx.neg, qr);
		last.result_value   = lctx.is_div ? div_fin[W-1:0] : lctx.res;
		last.compare_true   = lctx.cmp;
		last.overflow       = lctx.is_div ? div_fin[W] : lctx.ov;
		last.divide_by_zero = lctx.dz;
	end

	// output register with skid
	logic skid_q;
	rsp_t skid_data_q;
	logic out_ready;

	assign out_ready = !rsp_valid || !rsp_stall;
	assign req_stall = skid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
			skid_q    <= 1'b0;
		end else if (out_ready) begin
			rsp_valid <= skid_q || cv[NB];
			skid_q    <= 1'b0;
		end else if (en && cv[NB]) begin
			skid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready) begin
			rsp <= skid_q ? skid_data_q : last;
		end else if (en && cv[NB]) begin
			skid_data_q <= last;
		end
	end

endmodule

`default_nettype wire

>>> tb/fixed_point_q24_8_alu_unit_tb.sv
// testbench for the q24.8 fixed-point alu: directed and random transfers checked against
// an in-bench predictor of every opcode
// depends on fpa_pkg and the fixed_point_q24_8_alu_unit rtl
`timescale 1ns / 1ps

module fixed_point_q24_8_alu_unit_tb;
	import fpa_pkg::*;

	localparam int FRAC = 8;
	localparam int LATENCY = 43;
	localparam int CYCLE_LIMIT = 200000;

	logic  clk;
	logic  arst_n;
	logic  req_valid;
	logic  req_stall;
	req_t  req;
	logic  rsp_valid;
	logic  rsp_stall = 1'b0;
	rsp_t  rsp;

	rsp_t  expected_rsps[$];
	int    error_count;
	int    cycle_count = 0;
	bit    quiet_mode;

	fixed_point_q24_8_alu_unit #(.FRAC_BITS(FRAC)) DUT (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// saturate a signed wide value to the word
	function automatic logic [32:0] sat_word(input logic signed [127:0] v);
		if (v > 128'sd2147483647) return {1'b1, SAT_POS};
		if (v < -128'sd2147483648) return {1'b1, SAT_NEG};
		return {1'b0, v[31:0]};
	endfunction

	function automatic rsp_t alu_predict(input req_t r);
		rsp_t o;
		logic signed [127:0] a, b, ma, mb, q, rm, v;
		logic [32:0] s;
		bit neg;
		o = '0;
		a = 128'(r.operand_a);
		b = 128'(r.operand_b);
		unique case (op_t'(r.opcode))
			OP_ADD: begin s = sat_word(a + b); {o.overflow, o.result_value} = s; end
			OP_SUB: begin s = sat_word(a - b); {o.overflow, o.result_value} = s; end
			OP_INC: begin s = sat_word(a + 1); {o.overflow, o.result_value} = s; end
			OP_DEC: begin s = sat_word(a - 1); {o.overflow, o.result_value} = s; end
			OP_MUL: begin
				neg = (a < 0) != (b < 0);
				ma = (a < 0) ? -a : a;
				mb = (b < 0) ? -b : b;
				q = (ma * mb + (1 << (FRAC - 1))) >> FRAC;
				v = neg ? -q : q;
				s = sat_word(v);
				{o.overflow, o.result_value} = s;
			end
			OP_DIV: begin
				if (b == 0) begin
					o.divide_by_zero = 1'b1;
					o.result_value = (a < 0) ? SAT_NEG : SAT_POS;
				end else begin
					neg = (a < 0) != (b < 0);
					ma = (a < 0) ? -a : a;
					mb = (b < 0) ? -b : b;
					q = (ma << FRAC) / mb;
					rm = (ma << FRAC) % mb;
					if (rm >= mb - rm) q = q + 1;
					v = neg ? -q : q;
					s = sat_word(v);
					{o.overflow, o.result_value} = s;
				end
			end
			OP_LT: o.compare_true = a < b;
			OP_GT: o.compare_true = a > b;
			OP_LE: o.compare_true = a <= b;
			OP_GE: o.compare_true = a >= b;
			OP_EQ: o.compare_true = a == b;
			OP_NE: o.compare_true = a != b;
			OP_MIN: o.result_value = (a < b) ? a[31:0] : b[31:0];
			OP_MAX: o.result_value = (b < a) ? a[31:0] : b[31:0];
			OP_FROM: begin s = sat_word(a <<< FRAC); {o.overflow, o.result_value} = s; end
			default: o.result_value = r.operand_a >>> FRAC;
		endcase
		return o;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %h expected %h", what, got, want);
		error_count++;
	endtask

	function automatic bit idle_now();
		return !quiet_mode && ($urandom_range(99) < 31);
	endfunction

	// one transfer; valid stays high across back-to-back items
	task automatic send_item(input op_t op, input logic [31:0] a, input logic [31:0] b);
		req_t r;
		r.opcode = op;
		r.operand_a = a;
		r.operand_b = b;
		while (idle_now()) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		expected_rsps.push_back(alu_predict(r));
	endtask

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (arst_n) begin
			rsp_stall <= idle_now();
			if (rsp_valid && !rsp_stall) begin
				if (expected_rsps.size() == 0) begin
					report_mismatch("unexpected transfer", rsp.result_value, 32'h0);
				end else begin
					rsp_t e;
					e = expected_rsps.pop_front();
					if (rsp.result_value !== e.result_value)
						report_mismatch("result_value", rsp.result_value, e.result_value);
					if (rsp.compare_true !== e.compare_true)
						report_mismatch("compare_true", 32'(rsp.compare_true),
							32'(e.compare_true));
					if (rsp.overflow !== e.overflow)
						report_mismatch("overflow", 32'(rsp.overflow), 32'(e.overflow));
					if (rsp.divide_by_zero !== e.divide_by_zero)
						report_mismatch("divide_by_zero", 32'(rsp.divide_by_zero),
							32'(e.divide_by_zero));
				end
			end
		end
	end

	initial begin
		@(posedge clk);
		while (cycle_count < CYCLE_LIMIT) @(posedge clk);
		$display("RESULT: ERROR");
		$finish;
	end

	task automatic test_extremes();
		logic [31:0] ext[6];
		ext = '{32'h7fffffff, 32'h80000000, 32'h0, 32'hffffffff, 32'h00000100, 32'h00000001};
		for (int i = 0; i < 16; i++)
			send_item(op_t'(i), ext[i % 6], ext[(i + 1) % 6]);
		send_item(OP_DIV, 32'h80000000, 32'h0);
		send_item(OP_DIV, 32'h0, 32'h0);
		send_item(OP_MUL, 32'h80000000, 32'h80000000);
		send_item(OP_DIV, 32'h80000000, 32'hffffffff);
		send_item(OP_FROM, 32'h007fffff, 32'h0);
		send_item(OP_FROM, 32'hff800000, 32'h0);
		send_item(OP_MIN, 32'h5, 32'h5);
		send_item(OP_DIV, 32'h00000003, 32'h00000200);
	endtask

	function automatic logic [31:0] rand_operand();
		case ($urandom_range(3))
			0: return $urandom_range(2047) - 1024;
			1: return {$urandom_range(1) ? 8'hff : 8'h00, 24'($urandom)};
			default: return $urandom;
		endcase
	endfunction

	task automatic test_random(input int n);
		for (int i = 0; i < n; i++)
			send_item(op_t'($urandom_range(15)), rand_operand(), rand_operand());
	endtask

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		error_count = 0;
		quiet_mode = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_random(250);
		// stretch with no idling on either side
		quiet_mode = 1'b1;
		test_random(100);
		quiet_mode = 1'b0;
		test_random(50);
		req_valid <= 1'b0;
		while (expected_rsps.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (error_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

>>> fixed_point_q24_8_alu_unit.f
rtl/fpa_pkg.sv
rtl/fpa_cell.sv
rtl/fixed_point_q24_8_alu_unit.sv
tb/fixed_point_q24_8_alu_unit_tb.sv
